// ----- rtl/core/fkks_pkg.sv -----
// Package for the FASTA k-mer key stream unit: widths, character codes and item types.
// Used by the front part, the back part, the top module and the testbench; depends on nothing.
package fkks_pkg;

    localparam int BYTE_W            = 8;
    localparam int KLEN_W            = 6;
    localparam int KEY_W             = 29;
    localparam int START_W           = 32;
    localparam int SRC_W             = 64;
    localparam int MAX_KMER_DEF      = 32;
    localparam int POSITION_BITS_DEF = 32;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

    localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd32;
    localparam logic [KEY_W-1:0]  KEY_MOD    = 29'h1FFF_FFFF;

    localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_GT   = 8'h3E;
    localparam logic [BYTE_W-1:0] CHAR_A_UP = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_C_UP = 8'h43;
    localparam logic [BYTE_W-1:0] CHAR_G_UP = 8'h47;
    localparam logic [BYTE_W-1:0] CHAR_T_UP = 8'h54;
    localparam logic [BYTE_W-1:0] CHAR_A_LO = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_C_LO = 8'h63;
    localparam logic [BYTE_W-1:0] CHAR_G_LO = 8'h67;
    localparam logic [BYTE_W-1:0] CHAR_T_LO = 8'h74;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    typedef struct packed {
        logic [SRC_W-1:0]   window;
        logic [START_W-1:0] start;
    } t_kmer_item;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [START_W-1:0] start;
    } t_key_item;

endpackage

// ----- rtl/core/fkks_fifo.sv -----
// Small register FIFO used for the queue between front and back and for the result queue.
// Depends on nothing; depth must be a power of two of at least two.
module fkks_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_push_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_pop_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_count    = r_count;
    assign o_pop_data = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;

    always_comb begin
        n_wr    = do_push ? r_wr + 1'b1 : r_wr;
        n_rd    = do_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// ----- rtl/core/fkks_front.sv -----
// Front part: parses FASTA text, keeps the base window, counts and index, and issues windows.
// Depends on fkks_pkg.
module fkks_front import fkks_pkg::*; #(
    parameter int MAX_KMER      = MAX_KMER_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [KLEN_W-1:0] i_kmer_length,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_text_byte,
    output logic              o_item_valid,
    output t_kmer_item        o_item
);

    localparam int WW = 2 * MAX_KMER;
    localparam int CW = $clog2(MAX_KMER + 1);
    localparam int PE = (POSITION_BITS > START_W) ? POSITION_BITS : START_W;

    logic [KLEN_W-1:0]        r_kmer_length;
    logic [WW-1:0]            r_window;
    logic [CW-1:0]            r_count;
    logic [POSITION_BITS-1:0] r_index;
    logic                     r_at_line_start;
    logic                     r_in_header;
    logic [WW-1:0]            n_window;
    logic [CW-1:0]            n_count;
    logic [POSITION_BITS-1:0] n_index;
    logic                     n_at_line_start;
    logic                     n_in_header;

    logic [KLEN_W-1:0]        k_eff;
    logic [1:0]               code;
    logic                     known;
    logic                     is_base;
    logic [WW-1:0]            masked;
    logic [POSITION_BITS-1:0] start_full;
    logic [PE-1:0]            start_ext;

    always_comb begin
        k_eff = r_kmer_length;
        if (r_kmer_length == '0 || r_kmer_length > KLEN_W'(MAX_KMER)) begin
            k_eff = KLEN_W'(MAX_KMER);
        end
    end

    always_comb begin
        known = 1'b1;
        code  = CODE_A;
        case (i_text_byte)
            CHAR_A_UP, CHAR_A_LO: code = CODE_A;
            CHAR_C_UP, CHAR_C_LO: code = CODE_C;
            CHAR_G_UP, CHAR_G_LO: code = CODE_G;
            CHAR_T_UP, CHAR_T_LO: code = CODE_T;
            default:              known = 1'b0;
        endcase
    end

    assign is_base = !r_in_header && !(r_at_line_start && i_text_byte == CHAR_GT)
                     && !(i_text_byte inside {[8'd0:8'd32], [8'd128:8'd255]});

    always_comb begin
        n_window        = r_window;
        n_count         = r_count;
        n_index         = r_index;
        n_at_line_start = r_at_line_start;
        n_in_header     = r_in_header;
        if (i_accept) begin
            n_at_line_start = (i_text_byte == CHAR_LF);
            if (r_in_header) begin
                if (i_text_byte == CHAR_LF) begin
                    n_in_header = 1'b0;
                end
            end else if (r_at_line_start && i_text_byte == CHAR_GT) begin
                n_in_header = 1'b1;
            end else if (is_base) begin
                n_index = r_index + 1'b1;
                if (known) begin
                    n_window = (r_window << 2) | WW'(code);
                    if (r_count < CW'(MAX_KMER)) begin
                        n_count = r_count + 1'b1;
                    end
                end else begin
                    n_window = r_window << 2;
                    n_count  = '0;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WW; i++) begin
            masked[i] = n_window[i] & (7'(i) < {1'b0, k_eff} + {1'b0, k_eff});
        end
    end

    assign start_full = r_index + 1'b1 - POSITION_BITS'(k_eff);
    assign start_ext  = PE'(start_full);

    assign o_item_valid  = i_accept && is_base && known && (7'(n_count) >= 7'(k_eff));
    assign o_item.window = SRC_W'(masked);
    assign o_item.start  = start_ext[START_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length   <= KLEN_RESET;
            r_window        <= '0;
            r_count         <= '0;
            r_index         <= '0;
            r_at_line_start <= 1'b1;
            r_in_header     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_kmer_length <= i_kmer_length;
            end
            r_window        <= n_window;
            r_count         <= n_count;
            r_index         <= n_index;
            r_at_line_start <= n_at_line_start;
            r_in_header     <= n_in_header;
        end
    end

endmodule

// ----- rtl/core/fkks_back.sv -----
// Back part: two-stage fold of the 64-bit window modulo 2^29-1 with space reservation.
// Depends on fkks_pkg.
module fkks_back import fkks_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    input  t_kmer_item        i_item,
    output logic              o_item_pop,
    input  logic [QCNT_W-1:0] i_out_count,
    output logic              o_key_valid,
    output t_key_item         o_key_item
);

    logic                     r_v1;
    logic [KEY_W+1:0]         r_sum1;
    logic [START_W-1:0]       r_start1;
    logic                     r_v2;
    t_key_item                r_item2;
    logic [QCNT_W:0]          reserved;
    logic [KEY_W+1:0]         sum1;
    logic [KEY_W:0]           fold2;
    logic [KEY_W-1:0]         key2;

    assign reserved   = (QCNT_W+1)'(i_out_count) + (QCNT_W+1)'(r_v1) + (QCNT_W+1)'(r_v2);
    assign o_item_pop = i_item_valid && (reserved < (QCNT_W+1)'(QUEUE_DEPTH));

    assign sum1 = (KEY_W+2)'(i_item.window[KEY_W-1:0])
                + (KEY_W+2)'(i_item.window[2*KEY_W-1:KEY_W])
                + (KEY_W+2)'(i_item.window[SRC_W-1:2*KEY_W]);

    always_comb begin
        fold2 = (KEY_W+1)'(r_sum1[KEY_W-1:0]) + (KEY_W+1)'(r_sum1[KEY_W+1:KEY_W]);
        if (fold2 >= (KEY_W+1)'(KEY_MOD)) begin
            key2 = KEY_W'(fold2 - (KEY_W+1)'(KEY_MOD));
        end else begin
            key2 = fold2[KEY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= o_item_pop;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum1        <= sum1;
        r_start1      <= i_item.start;
        r_item2.key   <= key2;
        r_item2.start <= r_start1;
    end

    assign o_key_valid = r_v2;
    assign o_key_item  = r_item2;

endmodule

// ----- rtl/core/fasta_kmer_key_stream_unit.sv -----
// FASTA k-mer key stream unit: one text byte per cycle in while full is low, one key per qualifying base out.
// A byte that completes a window has its key pass the middle queue, both fold registers and the result queue.
// Throughput is one byte per cycle while the middle queue is not full, set by the window update in the front part.
// Reset is synchronous and active low; it empties both queues, sets the length register to 32,
// clears the window, base count and index and marks the next byte as a line start.
module fasta_kmer_key_stream_unit import fkks_pkg::*; #(
    parameter int MAX_KMER      = MAX_KMER_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [KLEN_W-1:0]  i_kmer_length,
    input  logic               push,
    output logic               full,
    input  logic [BYTE_W-1:0]  i_text_byte,
    output logic               empty,
    input  logic               pop,
    output logic [KEY_W-1:0]   o_key,
    output logic [START_W-1:0] o_start_position
);

    localparam int MID_W = $bits(t_kmer_item);
    localparam int OUT_W = $bits(t_key_item);

    logic              accept;
    logic              front_valid;
    t_kmer_item        front_item;
    logic [MID_W-1:0]  mid_data;
    logic              mid_empty;
    logic [QCNT_W-1:0] mid_count;
    logic              back_pop;
    t_kmer_item        back_item;
    logic              key_valid;
    t_key_item         key_item;
    logic [OUT_W-1:0]  out_data;
    logic              out_full;
    logic [QCNT_W-1:0] out_count;
    t_key_item         head;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    fkks_front #(
        .MAX_KMER      (MAX_KMER),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_kmer_length (i_kmer_length),
        .i_accept      (accept),
        .i_text_byte   (i_text_byte),
        .o_item_valid  (front_valid),
        .o_item        (front_item)
    );

    fkks_fifo #(
        .WIDTH (MID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_valid),
        .i_push_data (front_item),
        .o_full      (full),
        .i_pop       (back_pop),
        .o_pop_data  (mid_data),
        .o_empty     (mid_empty),
        .o_count     (mid_count)
    );

    assign back_item = t_kmer_item'(mid_data);

    fkks_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (!mid_empty && (mid_count != '0)),
        .i_item       (back_item),
        .o_item_pop   (back_pop),
        .i_out_count  (out_count),
        .o_key_valid  (key_valid),
        .o_key_item   (key_item)
    );

    fkks_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (key_valid),
        .i_push_data (key_item),
        .o_full      (out_full),
        .i_pop       (pop),
        .o_pop_data  (out_data),
        .o_empty     (empty),
        .o_count     (out_count)
    );

    assign head             = t_key_item'(out_data);
    assign o_key            = head.key;
    assign o_start_position = head.start;

endmodule

// ----- tb/tb_fasta_kmer_key_stream_unit.sv -----
// Testbench for fasta_kmer_key_stream_unit: drives FASTA text bytes, predicts every key and start
// position in a local model of the window logic, and checks each result transfer against it.
// Depends on fkks_pkg and the unit itself.
`timescale 1ns / 100ps

module tb_fasta_kmer_key_stream_unit import fkks_pkg::*;;

    localparam int unsigned LIMIT_CYCLES  = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned RANDOM_BYTES  = 750;

    localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SP   = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_BANG = 8'h21;
    localparam logic [BYTE_W-1:0] CHAR_N_UP = 8'h4E;
    localparam logic [BYTE_W-1:0] CHAR_N_LO = 8'h6E;
    localparam logic [BYTE_W-1:0] CHAR_DEL  = 8'h7F;
    localparam logic [BYTE_W-1:0] HIGH_MIN  = 8'h80;
    localparam logic [BYTE_W-1:0] BYTE_MAX  = 8'hFF;
    localparam logic [BYTE_W-1:0] FIRST_BASE_CHAR = 8'd33;
    localparam logic [BYTE_W-1:0] LAST_BASE_CHAR  = 8'd127;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [KLEN_W-1:0]  i_kmer_length = '0;
    logic               push = 1'b0;
    logic               full;
    logic [BYTE_W-1:0]  i_text_byte = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [KEY_W-1:0]   o_key;
    logic [START_W-1:0] o_start_position;

    // Local model of the unit's state.
    logic [SRC_W-1:0]   pred_window = '0;
    logic [KLEN_W-1:0]  pred_since = '0;
    logic [START_W-1:0] pred_next_index = '0;
    logic [KLEN_W-1:0]  pred_klen = KLEN_RESET;
    bit                 pred_line_start = 1'b1;
    bit                 pred_in_header = 1'b0;

    t_key_item key_expect_q[$];

    int unsigned bytes_sent = 0;
    int unsigned keys_checked = 0;
    int unsigned length_writes = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          offering = 1'b0;
    bit          calm_input = 1'b0;
    bit          calm_output = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned hold_left = 0;
    int unsigned pop_gap = 0;

    fasta_kmer_key_stream_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_kmer_length    (i_kmer_length),
        .push             (push),
        .full             (full),
        .i_text_byte      (i_text_byte),
        .empty            (empty),
        .pop              (pop),
        .o_key            (o_key),
        .o_start_position (o_start_position)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d keys still awaited", $time, key_expect_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned effective_klen(input logic [KLEN_W-1:0] k);
        if (k == 0 || k > MAX_KMER_DEF) return MAX_KMER_DEF;
        return k;
    endfunction

    task automatic predict_text_byte(input logic [BYTE_W-1:0] b);
        bit               was_line_start;
        bit               known;
        logic [1:0]       code;
        int unsigned      k;
        logic [START_W-1:0] idx;
        logic [SRC_W-1:0] win;
        t_key_item        item;
        was_line_start = pred_line_start;
        pred_line_start = (b == CHAR_LF);
        if (pred_in_header) begin
            if (b == CHAR_LF) pred_in_header = 1'b0;
            return;
        end
        if (was_line_start && b == CHAR_GT) begin
            pred_in_header = 1'b1;
            return;
        end
        if (b < FIRST_BASE_CHAR || b > LAST_BASE_CHAR) return;
        k = effective_klen(pred_klen);
        idx = pred_next_index;
        pred_next_index = idx + 1'b1;
        known = 1'b1;
        code = CODE_A;
        case (b)
            CHAR_A_UP, CHAR_A_LO: code = CODE_A;
            CHAR_C_UP, CHAR_C_LO: code = CODE_C;
            CHAR_G_UP, CHAR_G_LO: code = CODE_G;
            CHAR_T_UP, CHAR_T_LO: code = CODE_T;
            default: known = 1'b0;
        endcase
        if (!known) begin
            pred_window = pred_window << 2;
            pred_since = '0;
            return;
        end
        pred_window = (pred_window << 2) | SRC_W'(code);
        if (pred_since < MAX_KMER_DEF) pred_since++;
        if (pred_since < k) return;
        win = (k >= MAX_KMER_DEF) ? pred_window : (pred_window & ((64'd1 << (2 * k)) - 64'd1));
        item.key = KEY_W'(win % SRC_W'(KEY_MOD));
        item.start = idx - START_W'(k) + 1'b1;
        key_expect_q = {key_expect_q, item};
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        push <= 1'b1;
        i_text_byte <= b;
        offering = 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_text_byte(b);
        bytes_sent++;
        gap = pick_gap(calm_input);
        if (gap > 0) begin
            push <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic stop_input();
        if (offering) begin
            push <= 1'b0;
            offering = 1'b0;
        end
        @(posedge i_clk);
    endtask

    task automatic wait_results_drained();
        while (key_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_kmer_length(input logic [KLEN_W-1:0] v);
        stop_input();
        wait_results_drained();
        i_cfg_valid <= 1'b1;
        i_kmer_length <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        pred_klen = v;
        length_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] random_base_char();
        case ($urandom_range(0, 7))
            0: return CHAR_A_UP;
            1: return CHAR_C_UP;
            2: return CHAR_G_UP;
            3: return CHAR_T_UP;
            4: return CHAR_A_LO;
            5: return CHAR_C_LO;
            6: return CHAR_G_LO;
            default: return CHAR_T_LO;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] sequence_char();
        int unsigned r;
        r = $urandom_range(0, 299);
        if (r < 2) return CHAR_N_UP;
        if (r < 3) return CHAR_N_LO;
        if (r < 4) return BYTE_W'($urandom_range(FIRST_BASE_CHAR, LAST_BASE_CHAR));
        if (r < 5) return CHAR_SP;
        if (r < 6) return BYTE_W'($urandom_range(HIGH_MIN, BYTE_MAX));
        return random_base_char();
    endfunction

    task automatic send_record(input int unsigned n_bases);
        int unsigned hdr_len;
        int unsigned line_left;
        int unsigned i;
        hdr_len = $urandom_range(0, 12);
        send_byte(CHAR_GT);
        for (i = 0; i < hdr_len; i++) send_byte(BYTE_W'($urandom_range(32, 126)));
        send_byte(CHAR_LF);
        line_left = $urandom_range(1, 60);
        for (i = 0; i < n_bases; i++) begin
            send_byte(sequence_char());
            line_left--;
            if (line_left == 0) begin
                if ($urandom_range(0, 3) == 0) send_byte(CHAR_CR);
                send_byte(CHAR_LF);
                line_left = $urandom_range(1, 60);
            end
        end
        send_byte(CHAR_LF);
    endtask

    function automatic logic [KLEN_W-1:0] random_length();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return KLEN_W'($urandom_range(1, 8));
        if (r < 8) return KLEN_W'($urandom_range(9, 32));
        return KLEN_W'($urandom_range(0, 63));
    endfunction

    task automatic test_reset_length();
        send_record(90);
    endtask

    task automatic test_special_cases();
        logic [BYTE_W-1:0] seq[$];
        seq = '{CHAR_A_UP, CHAR_C_LO, CHAR_G_UP, CHAR_T_LO, CHAR_N_UP, CHAR_A_LO, CHAR_GT,
                CHAR_C_UP, CHAR_NUL, CHAR_SP, HIGH_MIN, BYTE_MAX, CHAR_G_LO, CHAR_DEL,
                CHAR_T_UP, CHAR_BANG, CHAR_A_UP, CHAR_LF, CHAR_GT, CHAR_C_UP, CHAR_G_UP,
                CHAR_LF, CHAR_T_LO, CHAR_G_UP};
        write_kmer_length(KLEN_W'(2));
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_length_sweep();
        logic [KLEN_W-1:0] lengths[$];
        lengths = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd33, 6'd2, 6'd31, 6'd16};
        foreach (lengths[i]) begin
            write_kmer_length(lengths[i]);
            calm_input = (i % 3 == 1);
            calm_output = (i % 4 == 2);
            send_record($urandom_range(60, 120));
        end
        calm_input = 1'b0;
        calm_output = 1'b0;
    endtask

    task automatic test_backpressure();
        int unsigned i;
        write_kmer_length(KLEN_W'(1));
        calm_input = 1'b1;
        hold_req = 1'b1;
        for (i = 0; i < 60; i++) send_byte(random_base_char());
        calm_input = 1'b0;
        stop_input();
        wait_results_drained();
        send_record(40);
    endtask

    task automatic test_random_stream();
        int unsigned stop_at;
        int unsigned chunk_end;
        int unsigned r;
        int unsigned i;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            write_kmer_length(random_length());
            calm_input = ($urandom_range(0, 4) == 0);
            calm_output = ($urandom_range(0, 4) == 0);
            chunk_end = bytes_sent + $urandom_range(150, 350);
            while (bytes_sent < chunk_end) begin
                r = $urandom_range(0, 9);
                if (r < 8) begin
                    send_record($urandom_range(1, 120));
                end else if (r == 8) begin
                    for (i = $urandom_range(1, 8); i > 0; i--) send_byte(BYTE_W'($urandom));
                    if ($urandom_range(0, 1) == 0) send_byte(CHAR_LF);
                end else begin
                    // A stray '>' inside a line, then a header left open until the next newline.
                    send_byte(random_base_char());
                    send_byte(CHAR_GT);
                    send_byte(random_base_char());
                    send_byte(CHAR_LF);
                    send_byte(CHAR_GT);
                    for (i = $urandom_range(0, 6); i > 0; i--) send_byte(random_base_char());
                    send_byte(CHAR_LF);
                end
            end
        end
        calm_input = 1'b0;
        calm_output = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            pop <= 1'b0;
        end else begin
            if (pop && !empty) pop_gap = pick_gap(calm_output);
            if (pop_gap > 0) begin
                pop <= 1'b0;
                pop_gap--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_key_item want;
        if (i_rst_n && pop && !empty) begin
            if (key_expect_q.size() == 0) begin
                $display("%0t: key transfer with none expected, actual key %h start %h",
                         $time, o_key, o_start_position);
                error_count++;
            end else begin
                want = key_expect_q.pop_front();
                keys_checked++;
                if (o_key !== want.key) begin
                    $display("%0t: key mismatch, expected %h actual %h",
                             $time, want.key, o_key);
                    error_count++;
                end
                if (o_start_position !== want.start) begin
                    $display("%0t: start position mismatch, expected %h actual %h",
                             $time, want.start, o_start_position);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_length();
        test_special_cases();
        test_length_sweep();
        test_backpressure();
        test_random_stream();

        stop_input();
        wait_results_drained();
        repeat (20) @(posedge i_clk);
        if (key_expect_q.size() != 0) begin
            $display("%0t: %0d keys never arrived", $time, key_expect_q.size());
            error_count++;
        end

        $display("Run covered %0d text bytes, %0d keys checked, %0d window length writes,",
                 bytes_sent, keys_checked, length_writes);
        $display("with headers, unknown bases, ignored bytes and a long output stall.");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- fasta_kmer_key_stream_unit.f -----
rtl/core/fkks_pkg.sv
rtl/core/fkks_fifo.sv
rtl/core/fkks_front.sv
rtl/core/fkks_back.sv
rtl/core/fasta_kmer_key_stream_unit.sv
tb/tb_fasta_kmer_key_stream_unit.sv
